// ===== sv/ecd_pkg.sv =====
// Shared types, constants and small tables for the epoch-to-date converter.
// No dependencies; every other file refers to it by scoped names.
`default_nettype none

package ecd_pkg;

	// Reciprocal multipliers: q = (x * MUL) >> SHIFT, exact over each operand range
	localparam logic [31:0] DIV60_MUL_A   = 32'h8888_8889;  // x < 2^31
	localparam int          DIV60_SHIFT_A = 37;
	localparam logic [26:0] DIV60_MUL_B   = 27'd71582789;   // x < 2^26
	localparam int          DIV60_SHIFT_B = 32;
	localparam logic [20:0] DIV24_MUL     = 21'd1398102;    // x < 2^20
	localparam int          DIV24_SHIFT   = 25;
	localparam logic [18:0] DIV1461_MUL   = 19'd367469;     // x < 2^18
	localparam int          DIV1461_SHIFT = 29;
	localparam logic [11:0] DIV153_MUL    = 12'd3427;       // x < 2^11
	localparam int          DIV153_SHIFT  = 19;

	// Day-number method: the 100-year period index (cent) is 0 or 1 over the input range
	localparam logic [14:0] CENT_SPLIT_DAY = 15'd11017;  // first day with period 1
	localparam logic [15:0] CENT_EARLY_OFS = 16'd25508;  // c = day + this, period 0
	localparam logic [10:0] QUAD_YEAR_DAYS = 11'd1461;
	localparam logic [7:0]  CENT_YEARS     = 8'd100;

	typedef struct packed {
		logic        valid;
		logic        neg;
		logic [5:0]  sec;
		logic [5:0]  min;
		logic [19:0] hl;
	} hms_t;

	typedef struct packed {
		logic        valid;
		logic        neg;
		logic [5:0]  sec;
		logic [5:0]  min;
		logic [4:0]  hour;
		logic        cent;
		logic [15:0] c;
	} dayc_t;

	// First day-of-year (March based) of shifted month m
	function automatic logic [8:0] month_start(input logic [3:0] m);
		logic [8:0] r;
		case (m)
			4'd0:    r = 9'd0;
			4'd1:    r = 9'd31;
			4'd2:    r = 9'd61;
			4'd3:    r = 9'd92;
			4'd4:    r = 9'd122;
			4'd5:    r = 9'd153;
			4'd6:    r = 9'd184;
			4'd7:    r = 9'd214;
			4'd8:    r = 9'd245;
			4'd9:    r = 9'd275;
			4'd10:   r = 9'd306;
			4'd11:   r = 9'd337;
			default: r = 9'd0;
		endcase
		return r;
	endfunction

	// Shifted month to calendar month, 0 is January
	function automatic logic [3:0] month_num(input logic [3:0] m);
		logic [3:0] r;
		if (m >= 4'd10) begin
			r = m - 4'd10;
		end else begin
			r = m + 4'd2;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== sv/ecd_hms.sv =====
// Seconds count to second, minute and local hour count (stages 1-4).
// Depends on ecd_pkg.
`default_nettype none

module ecd_hms (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         in_valid,
	input  wire logic [30:0]  secs,
	input  wire logic [4:0]   zone,
	output ecd_pkg::hms_t     hms
);

	logic        valid_s1, valid_s2, valid_s3, valid_s4;
	logic [30:0] secs_s1, secs_s2;
	logic [25:0] mins_s2;
	logic [19:0] hours_s3;
	logic [5:0]  mins_lo_s3, sec_s3, sec_s4, min_s4;
	logic        neg_s4;
	logic [19:0] hl_s4;

	logic [62:0] prod_a;
	logic [52:0] prod_b;
	logic [21:0] hl_sum;

	always_comb begin
		prod_a = 63'(secs_s1) * 63'(ecd_pkg::DIV60_MUL_A);
		prod_b = 53'(mins_s2) * 53'(ecd_pkg::DIV60_MUL_B);
		hl_sum = {2'b00, hours_s3} + {{17{zone[4]}}, zone};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		secs_s1    <= secs;
		mins_s2    <= prod_a[62:37];
		secs_s2    <= secs_s1;
		hours_s3   <= prod_b[51:32];
		// x - 60q == x + 4q modulo 64
		sec_s3     <= secs_s2[5:0] + {mins_s2[3:0], 2'b00};
		mins_lo_s3 <= mins_s2[5:0];
		min_s4     <= mins_lo_s3 + {hours_s3[3:0], 2'b00};
		sec_s4     <= sec_s3;
		neg_s4     <= hl_sum[21];
		hl_s4      <= hl_sum[19:0];
	end

	assign hms.valid = valid_s4;
	assign hms.neg   = neg_s4;
	assign hms.sec   = sec_s4;
	assign hms.min   = min_s4;
	assign hms.hl    = hl_s4;

endmodule

`default_nettype wire

// ===== sv/ecd_day.sv =====
// Local hour count to hour of day and day-in-cycle count (stages 5-6).
// Depends on ecd_pkg.
`default_nettype none

module ecd_day (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire ecd_pkg::hms_t hms,
	output ecd_pkg::dayc_t     dc
);

	logic        valid_s5, valid_s6;
	logic        neg_s5, neg_s6;
	logic [5:0]  sec_s5, min_s5, sec_s6, min_s6;
	logic [14:0] day_s5;
	logic [4:0]  hl_lo_s5, hour_s6;
	logic        cent_s6;
	logic [15:0] c_s6;

	logic [40:0] prod;
	logic        cent;

	always_comb begin
		prod = 41'(hms.hl) * 41'(ecd_pkg::DIV24_MUL);
		cent = (day_s5 >= ecd_pkg::CENT_SPLIT_DAY);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else begin
			valid_s5 <= hms.valid;
			valid_s6 <= valid_s5;
		end
	end

	always_ff @(posedge clk) begin
		day_s5   <= prod[39:25];
		hl_lo_s5 <= hms.hl[4:0];
		neg_s5   <= hms.neg;
		sec_s5   <= hms.sec;
		min_s5   <= hms.min;
		// h - 24d == h + 8d modulo 32
		hour_s6  <= hl_lo_s5 + {day_s5[1:0], 3'b000};
		cent_s6  <= cent;
		if (cent) begin
			c_s6 <= {1'b0, day_s5} - {1'b0, ecd_pkg::CENT_SPLIT_DAY};
		end else begin
			c_s6 <= {1'b0, day_s5} + ecd_pkg::CENT_EARLY_OFS;
		end
		neg_s6   <= neg_s5;
		sec_s6   <= sec_s5;
		min_s6   <= min_s5;
	end

	assign dc.valid = valid_s6;
	assign dc.neg   = neg_s6;
	assign dc.sec   = sec_s6;
	assign dc.min   = min_s6;
	assign dc.hour  = hour_s6;
	assign dc.cent  = cent_s6;
	assign dc.c     = c_s6;

endmodule

`default_nettype wire

// ===== sv/ecd_date.sv =====
// Day-in-cycle count to day of month, month and year (stages 7-10).
// Depends on ecd_pkg.
`default_nettype none

module ecd_date (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire ecd_pkg::dayc_t dc,
	output logic                done,
	output logic [5:0]          second,
	output logic [5:0]          minute,
	output logic [4:0]          hour,
	output logic [4:0]          day_of_month,
	output logic [3:0]          month_index,
	output logic [7:0]          years_since_1900,
	output logic                before_epoch
);

	logic        valid_s7, valid_s8, valid_s9, valid_s10;
	logic        neg_s7, neg_s8, neg_s9;
	logic [5:0]  sec_s7, min_s7, sec_s8, min_s8, sec_s9, min_s9;
	logic [4:0]  hour_s7, hour_s8, hour_s9;
	logic        cent_s7, cent_s8, cent_s9;
	logic [15:0] c_s7;
	logic [6:0]  d_s7, d_s8, d_s9;
	logic [8:0]  e_s8, e_s9;
	logic [3:0]  m_s9;

	logic [5:0]  sec_s10, min_s10;
	logic [4:0]  hour_s10, mday_s10;
	logic [3:0]  mon_s10;
	logic [7:0]  year_s10;
	logic        neg_s10;

	logic [17:0] x_d;
	logic [36:0] prod_d;
	logic [17:0] d_days;
	logic [10:0] x_m;
	logic [22:0] prod_m;
	logic        wrap;
	logic [8:0]  mday_w;
	logic [7:0]  year_w;

	always_comb begin
		x_d    = {dc.c, 2'b11};
		prod_d = 37'(x_d) * 37'(ecd_pkg::DIV1461_MUL);
		d_days = 18'(d_s7) * 18'(ecd_pkg::QUAD_YEAR_DAYS);
		x_m    = 11'({e_s8, 2'b00} + 11'(e_s8) + 11'd2);
		prod_m = 23'(x_m) * 23'(ecd_pkg::DIV153_MUL);
		wrap   = (m_s9 >= 4'd10);
		mday_w = e_s9 + 9'd1 - ecd_pkg::month_start(m_s9);
		year_w = (cent_s9 ? ecd_pkg::CENT_YEARS : 8'd0) + {1'b0, d_s9} + {7'd0, wrap};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s7  <= 1'b0;
			valid_s8  <= 1'b0;
			valid_s9  <= 1'b0;
			valid_s10 <= 1'b0;
		end else begin
			valid_s7  <= dc.valid;
			valid_s8  <= valid_s7;
			valid_s9  <= valid_s8;
			valid_s10 <= valid_s9;
		end
	end

	always_ff @(posedge clk) begin
		// stage 7: year within the 4-year-ish split of the cycle
		d_s7     <= prod_d[35:29];
		c_s7     <= dc.c;
		cent_s7  <= dc.cent;
		hour_s7  <= dc.hour;
		neg_s7   <= dc.neg;
		sec_s7   <= dc.sec;
		min_s7   <= dc.min;
		// stage 8: day within the March-based year
		e_s8     <= 9'(c_s7 - {2'b00, d_days[17:2]});
		d_s8     <= d_s7;
		cent_s8  <= cent_s7;
		hour_s8  <= hour_s7;
		neg_s8   <= neg_s7;
		sec_s8   <= sec_s7;
		min_s8   <= min_s7;
		// stage 9: March-based month
		m_s9     <= prod_m[22:19];
		e_s9     <= e_s8;
		d_s9     <= d_s8;
		cent_s9  <= cent_s8;
		hour_s9  <= hour_s8;
		neg_s9   <= neg_s8;
		sec_s9   <= sec_s8;
		min_s9   <= min_s8;
		// stage 10: result register, hour and date fields cleared before the epoch
		sec_s10  <= sec_s9;
		min_s10  <= min_s9;
		neg_s10  <= neg_s9;
		if (neg_s9) begin
			hour_s10 <= 5'd0;
			mday_s10 <= 5'd0;
			mon_s10  <= 4'd0;
			year_s10 <= 8'd0;
		end else begin
			hour_s10 <= hour_s9;
			mday_s10 <= mday_w[4:0];
			mon_s10  <= ecd_pkg::month_num(m_s9);
			year_s10 <= year_w;
		end
	end

	assign done             = valid_s10;
	assign second           = sec_s10;
	assign minute           = min_s10;
	assign hour             = hour_s10;
	assign day_of_month     = mday_s10;
	assign month_index      = mon_s10;
	assign years_since_1900 = year_s10;
	assign before_epoch     = neg_s10;

endmodule

`default_nettype wire

// ===== sv/epoch_seconds_to_calendar_date_top.sv =====
// Unix seconds to local calendar date, ten-stage pipeline.
// Depends on ecd_pkg, ecd_hms, ecd_day and ecd_date.
//
// Usage:
//  - Request channel: drive unix_seconds and pulse start. A request is taken
//    at every rising edge with start high and busy low. busy is tied low:
//    the pipeline takes one request per cycle, back to back, with no gaps.
//  - Result channel: done is high for exactly one cycle with the result
//    fields valid in that cycle. Each request passes through ten register
//    stages, s1 to s10, before its result shows on the outputs.
//  - Throughput: one request per clock. The stages are cut around
//    two reciprocal multiplies for the /60 steps, one for /24, one each for
//    /1461 and /153, plus the cycle split and final table lookup.
//  - Config: cfg_we/cfg_wdata write the signed hour offset (zone). Write it
//    only with the pipeline empty; it is sampled by stage 4 of each request.
//  - before_epoch: set when the offset makes the local hour count negative;
//    hour, day, month and year then read zero, second and minute are kept.
//  - Reset (arst_n low): clears all stage valid bits and the offset to 0;
//    requests in flight are dropped, no done pulse follows.
//  - The receiver cannot stall: each result is offered for one cycle only.
`default_nettype none

module epoch_seconds_to_calendar_date_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [30:0] unix_seconds,
	input  wire logic        cfg_we,
	input  wire logic [4:0]  cfg_wdata,
	output logic             done,
	output logic [5:0]       second,
	output logic [5:0]       minute,
	output logic [4:0]       hour,
	output logic [4:0]       day_of_month,
	output logic [3:0]       month_index,
	output logic [7:0]       years_since_1900,
	output logic             before_epoch
);

	logic [4:0]      zone_q;
	ecd_pkg::hms_t   hms;
	ecd_pkg::dayc_t  dc;

	// Fully pipelined, never refuses a request
	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zone_q <= 5'd0;
		end else if (cfg_we) begin
			zone_q <= cfg_wdata;
		end
	end

	// stages 1-4: second, minute, local hour count
	ecd_hms u_hms (
		.clk    (clk),
		.arst_n (arst_n),
		.in_valid (start & ~busy),
		.secs   (unix_seconds),
		.zone   (zone_q),
		.hms    (hms)
	);

	// stages 5-6: hour of day, day count within the 100-year period
	ecd_day u_day (
		.clk    (clk),
		.arst_n (arst_n),
		.hms    (hms),
		.dc     (dc)
	);

	// stages 7-10: year, month, day of month, result register
	ecd_date u_date (
		.clk              (clk),
		.arst_n           (arst_n),
		.dc               (dc),
		.done             (done),
		.second           (second),
		.minute           (minute),
		.hour             (hour),
		.day_of_month     (day_of_month),
		.month_index      (month_index),
		.years_since_1900 (years_since_1900),
		.before_epoch     (before_epoch)
	);

endmodule

`default_nettype wire
